// File: rtl/tjbs_pkg.sv
// Shared types and constants for the two-joint blend skinning block.
// Request, response and internal command formats. No dependencies.
`default_nettype none
package tjbs_pkg;

   // Widest joint number and blend fraction that any configuration uses
   localparam int JOINT_W_MAX = 8;
   localparam int FRAC_W_MAX  = 24;
   // Fraction bits of positions, normals and matrix elements
   localparam int POS_FRAC    = 16;

   // Request kind codes
   localparam logic [1:0] KIND_LOAD  = 2'd0;
   localparam logic [1:0] KIND_PIVOT = 2'd1;
   localparam logic [1:0] KIND_SKIN  = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_PIVOT,
      OP_SKIN
   } op_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [4:0]         joint_index;
      logic [1:0]         row_index;
      logic signed [31:0] val_x;
      logic signed [31:0] val_y;
      logic signed [31:0] val_z;
      logic signed [31:0] val_w;
      logic [20:0]        blend_weight;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_norm_x;
      logic signed [31:0] out_norm_y;
      logic signed [31:0] out_norm_z;
   } rsp_type;

   // Classified command handed from the front end to the engine
   typedef struct packed {
      op_type                  op;
      logic [JOINT_W_MAX-1:0]  j0;
      logic [JOINT_W_MAX-1:0]  j1;
      logic [FRAC_W_MAX-1:0]   t;
      logic [1:0]              row;
      logic signed [31:0]      val_x;
      logic signed [31:0]      val_y;
      logic signed [31:0]      val_z;
      logic signed [31:0]      val_w;
      logic signed [31:0]      norm_x;
      logic signed [31:0]      norm_y;
      logic signed [31:0]      norm_z;
   } cmd_type;

endpackage
`default_nettype wire

// File: rtl/two_joint_blend_skinning.sv
// Two-joint blend skinning top level: front end, engine, response queue.
// A skin result reaches the rsp ports after dispatch, the element reads of
// its columns, four pipeline stages and the queue write.
// One command is in the engine at a time; one matrix element of each joint
// is read per cycle while a skin or pivot runs.
// Synchronous reset empties both queues; matrix memory is not cleared.
`default_nettype none
module two_joint_blend_skinning
   import tjbs_pkg::*;
#(
   parameter int JOINTS    = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    cmd_valid, cmd_pop, q_full, eng_push;
   cmd_type cmd_data;
   rsp_type eng_rsp;

   tjbs_front #(.JOINTS(JOINTS), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   tjbs_engine #(.JOINTS(JOINTS), .FRAC_BITS(FRAC_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_full  (q_full),
      .rsp_push  (eng_push),
      .rsp_out   (eng_rsp)
   );

   tjbs_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (eng_push),
      .wr_data (eng_rsp),
      .full    (q_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rsp_data)
   );

   // Checks
   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not empty after reset");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(eng_push && q_full))
      else $error("result pushed into full response queue");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("engine took a command from an empty queue");

endmodule
`default_nettype wire

// File: rtl/tjbs_front.sv
// Front end: decodes requests into commands and queues them (two entries).
// Depends on tjbs_pkg.
`default_nettype none
module tjbs_front
   import tjbs_pkg::*;
#(
   parameter int JOINTS    = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         cmd_valid,
   input  wire logic    cmd_pop,
   output cmd_type      cmd_data
);

   localparam logic [FRAC_W_MAX-1:0] TMASK =
      FRAC_W_MAX'((25'd1 << FRAC_BITS) - 25'd1);
   localparam logic [FRAC_W_MAX-1:0] LAST_J = FRAC_W_MAX'(JOINTS - 1);

   cmd_type                 q_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   cmd_type                 cmd;
   logic                    keep;
   logic                    in_range;
   logic [FRAC_W_MAX-1:0]   w24, k0w, k1w;
   logic                    do_push, do_pop;

   // Classify: joint clamp and blend fraction for skins, range check for writes
   always_comb begin
      w24      = {3'b000, req_data.blend_weight};
      k0w      = w24 >> FRAC_BITS;
      k1w      = k0w + FRAC_W_MAX'(1);
      if (k0w > LAST_J) k0w = LAST_J;
      if (k1w > LAST_J) k1w = LAST_J;
      in_range = {4'b0000, req_data.joint_index} < 9'(JOINTS);
      cmd.row    = req_data.row_index;
      cmd.val_x  = req_data.val_x;
      cmd.val_y  = req_data.val_y;
      cmd.val_z  = req_data.val_z;
      cmd.val_w  = req_data.val_w;
      cmd.norm_x = req_data.norm_x;
      cmd.norm_y = req_data.norm_y;
      cmd.norm_z = req_data.norm_z;
      cmd.j0     = {3'b000, req_data.joint_index};
      cmd.j1     = {3'b000, req_data.joint_index};
      cmd.t      = '0;
      cmd.op     = OP_LOAD;
      keep       = 1'b0;
      unique case (req_data.kind)
         KIND_LOAD: begin
            keep = in_range;
         end
         KIND_PIVOT: begin
            cmd.op = OP_PIVOT;
            keep   = in_range;
         end
         KIND_SKIN: begin
            cmd.op = OP_SKIN;
            cmd.j0 = k0w[JOINT_W_MAX-1:0];
            cmd.j1 = k1w[JOINT_W_MAX-1:0];
            cmd.t  = w24 & TMASK;
            keep   = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // Command queue
   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign do_push   = push && !full && keep;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

// File: rtl/tjbs_engine.sv
// Back end: joint matrix memory, lerp unit, position and normal MACs.
// Depends on tjbs_pkg.
`default_nettype none
module tjbs_engine
   import tjbs_pkg::*;
#(
   parameter int JOINTS    = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   input  wire cmd_type cmd_data,
   input  wire logic    rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp_out
);

   localparam int JW    = $clog2(JOINTS);
   localparam int AW    = JW + 4;
   localparam int DEPTH = JOINTS * 16;
   localparam int PW    = 34 + FRAC_BITS;

   typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_WAIT} state_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] row;
      logic [1:0] col;
      logic       last;
   } tag_type;

   function automatic logic signed [31:0] sat_q(input logic signed [65:0] acc);
      logic signed [65:0] s;
      begin
         s = acc >>> POS_FRAC;
         if (s > 66'sd2147483647) return 32'sh7fffffff;
         else if (s < -66'sd2147483648) return 32'sh80000000;
         return s[31:0];
      end
   endfunction

   logic signed [31:0] mem_ff [DEPTH];

   state_type          state_ff;
   cmd_type            cur_ff;
   logic [1:0]         row_ff, col_ff;
   tag_type            tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag0;
   logic signed [31:0] rd_a_ff, rd_b_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [31:0] base_ff;
   logic signed [31:0] blend_ff;
   logic signed [63:0] ppos_ff, pnrm_ff;
   logic signed [31:0] bias_ff;
   logic signed [65:0] accpos_ff, accpos_in, accnrm_ff, accnrm_in;
   logic signed [31:0] pos0_ff, pos1_ff, nrm0_ff, nrm1_ff;
   logic signed [65:0] tot_pos;
   logic signed [31:0] res_pos, res_nrm;
   logic [1:0]         last_col;
   logic               start;
   logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr;
   logic signed [31:0] wr_data, load_val, vsel, nsel;
   logic               wr_en;
   logic signed [32:0] diff;
   logic signed [FRAC_BITS:0] t_s;
   logic signed [PW-1:0] lsum;
   logic               fin;

   // Dispatch: a skin waits for room in the response queue
   assign start    = (state_ff == S_IDLE) && cmd_valid &&
                     ((cmd_data.op != OP_SKIN) || !rsp_full);
   assign cmd_pop  = start;
   assign last_col = (cur_ff.op == OP_PIVOT) ? 2'd3 : 2'd2;

   // Read issue: column by column, rows 0..3
   always_comb begin
      tag0.valid = (state_ff == S_RUN);
      tag0.row   = row_ff;
      tag0.col   = col_ff;
      tag0.last  = (row_ff == 2'd3) && (col_ff == last_col);
      rd_addr_a  = {cur_ff.j0[JW-1:0], row_ff, col_ff};
      rd_addr_b  = {cur_ff.j1[JW-1:0], row_ff, col_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 2'd0;
         col_ff   <= 2'd0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               row_ff <= 2'd0;
               col_ff <= 2'd0;
               if (start) begin
                  cur_ff   <= cmd_data;
                  state_ff <= (cmd_data.op == OP_LOAD) ? S_LOAD : S_RUN;
               end
            end
            S_LOAD: begin
               col_ff <= col_ff + 2'd1;
               if (col_ff == 2'd3) state_ff <= S_IDLE;
            end
            S_RUN: begin
               row_ff <= row_ff + 2'd1;
               if (row_ff == 2'd3) begin
                  col_ff <= col_ff + 2'd1;
                  if (col_ff == last_col) state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               if (tag4_ff.valid && tag4_ff.last) state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Memory write: row loads, or pivot writeback of row 3
   always_comb begin
      unique case (col_ff)
         2'd0: load_val = cur_ff.val_x;
         2'd1: load_val = cur_ff.val_y;
         2'd2: load_val = cur_ff.val_z;
         default: load_val = cur_ff.val_w;
      endcase
      if (state_ff == S_LOAD) begin
         wr_en   = 1'b1;
         wr_addr = {cur_ff.j0[JW-1:0], cur_ff.row, col_ff};
         wr_data = load_val;
      end else begin
         wr_en   = tag4_ff.valid && (tag4_ff.row == 2'd3) && (cur_ff.op == OP_PIVOT);
         wr_addr = {cur_ff.j0[JW-1:0], 2'd3, tag4_ff.col};
         wr_data = res_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   // Lerp: multiply then floor shift and add
   always_comb begin
      diff = 33'(rd_b_ff) - 33'(rd_a_ff);
      t_s  = $signed({1'b0, cur_ff.t[FRAC_BITS-1:0]});
      lsum = PW'(base_ff) + (prod_ff >>> FRAC_BITS);
      unique case (tag3_ff.row)
         2'd0: begin vsel = cur_ff.val_x; nsel = cur_ff.norm_x; end
         2'd1: begin vsel = cur_ff.val_y; nsel = cur_ff.norm_y; end
         2'd2: begin vsel = cur_ff.val_z; nsel = cur_ff.norm_z; end
         default: begin vsel = '0; nsel = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= PW'(diff) * PW'(t_s);
      base_ff  <= rd_a_ff;
      blend_ff <= lsum[31:0];
      ppos_ff  <= blend_ff * vsel;
      pnrm_ff  <= blend_ff * nsel;
      bias_ff  <= blend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
      end else begin
         tag1_ff <= tag0;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
      end
   end

   // Accumulate rows 0..2; row 3 adds the translation to the position, then floors and saturates
   always_comb begin
      accpos_in = accpos_ff;
      accnrm_in = accnrm_ff;
      if (tag4_ff.valid && (tag4_ff.row != 2'd3)) begin
         accpos_in = ((tag4_ff.row == 2'd0) ? 66'sd0 : accpos_ff) + 66'(ppos_ff);
         accnrm_in = ((tag4_ff.row == 2'd0) ? 66'sd0 : accnrm_ff) + 66'(pnrm_ff);
      end
      tot_pos = accpos_ff + (66'(bias_ff) <<< POS_FRAC);
      res_pos = sat_q(tot_pos);
      res_nrm = sat_q(accnrm_ff);
      fin     = tag4_ff.valid && (tag4_ff.row == 2'd3) && (cur_ff.op == OP_SKIN);
   end

   always_ff @(posedge clock) begin
      accpos_ff <= accpos_in;
      accnrm_ff <= accnrm_in;
      if (fin && (tag4_ff.col == 2'd0)) begin
         pos0_ff <= res_pos;
         nrm0_ff <= res_nrm;
      end
      if (fin && (tag4_ff.col == 2'd1)) begin
         pos1_ff <= res_pos;
         nrm1_ff <= res_nrm;
      end
   end

   // Result goes out with the last column
   assign rsp_push = fin && (tag4_ff.col == 2'd2);
   always_comb begin
      rsp_out.out_pos_x  = pos0_ff;
      rsp_out.out_pos_y  = pos1_ff;
      rsp_out.out_pos_z  = res_pos;
      rsp_out.out_norm_x = nrm0_ff;
      rsp_out.out_norm_y = nrm1_ff;
      rsp_out.out_norm_z = res_nrm;
   end

endmodule
`default_nettype wire

// File: rtl/tjbs_rsp_queue.sv
// Two-entry response queue between the engine and the result port.
// Depends on tjbs_pkg.
`default_nettype none
module tjbs_rsp_queue
   import tjbs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    wr_en,
   input  wire rsp_type wr_data,
   output logic         full,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rd_data
);

   rsp_type    q_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign rd_data = q_ff[rd_ptr_ff];
   assign do_push = wr_en && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ do_push;
         rd_ptr_ff <= rd_ptr_ff ^ do_pop;
         count_ff  <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) q_ff[wr_ptr_ff] <= wr_data;
   end

endmodule
`default_nettype wire
